### rtl/m3i_pkg.sv
`timescale 1ns / 1ps
package m3i_pkg;

  localparam int NUM_ENT   = 9;
  localparam int THR_BITS  = 31;
  localparam int THR_RESET = 1;

  // cofactor k = m[A]*m[B] - m[C]*m[D], adjugate order
  localparam int COF_A [NUM_ENT] = '{4, 2, 1, 5, 0, 3, 3, 6, 0};
  localparam int COF_B [NUM_ENT] = '{8, 7, 5, 6, 8, 2, 7, 1, 4};
  localparam int COF_C [NUM_ENT] = '{7, 1, 2, 3, 2, 0, 6, 0, 3};
  localparam int COF_D [NUM_ENT] = '{5, 8, 4, 8, 6, 5, 4, 7, 1};

  typedef struct packed {
    logic valid;
    logic singular;
  } m3i_ctl_t;

endpackage

### rtl/m3i_in_if.sv
`timescale 1ns / 1ps
interface m3i_in_if #(parameter int W = 32) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                output ready);
endinterface

### rtl/m3i_out_if.sv
`timescale 1ns / 1ps
interface m3i_out_if #(parameter int W = 32) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
  logic                singular;
  logic                saturated;

  modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  singular, saturated, input ready);
  modport sink (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                singular, saturated, output ready);
endinterface

### rtl/m3i_front.sv
`timescale 1ns / 1ps
module m3i_front #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic signed [W-1:0]            m [m3i_pkg::NUM_ENT],
  input  logic [m3i_pkg::THR_BITS-1:0]   thr,
  output m3i_pkg::m3i_ctl_t              ctl,
  output logic [2*W:0]                   cmag [m3i_pkg::NUM_ENT],
  output logic                           cneg [m3i_pkg::NUM_ENT],
  output logic [3*W+2:0]                 dmag,
  output logic                           dneg
);

  localparam int CW = 2 * W + 1;
  localparam int SW = CW + 2;
  localparam int DW = 3 * W + 3;
  localparam int TW = m3i_pkg::THR_BITS + 2 * F;
  localparam int LW = (DW > TW) ? DW : TW;

  logic signed [2*W-1:0] pa [m3i_pkg::NUM_ENT];
  logic signed [2*W-1:0] pb [m3i_pkg::NUM_ENT];
  logic signed [CW-1:0]  cf2 [m3i_pkg::NUM_ENT];
  logic signed [CW-1:0]  cf3 [m3i_pkg::NUM_ENT];
  logic signed [CW-1:0]  cf4 [m3i_pkg::NUM_ENT];
  logic signed [CW-1:0]  cf5 [m3i_pkg::NUM_ENT];
  logic signed [W-1:0]   row1 [3];
  logic signed [W-1:0]   row2 [3];
  logic signed [CW-1:0]  pl [3];
  logic signed [CW-1:0]  ph [3];
  logic signed [SW-1:0]  sl;
  logic signed [SW-1:0]  sh;
  logic signed [DW-1:0]  dt;
  logic [DW-1:0]         dabs;
  logic [LW-1:0]         lim;
  logic [4:0]            v;

  assign dabs = dt[DW-1] ? DW'(~dt + DW'(1)) : DW'(dt);
  assign lim  = LW'(thr) << (2 * F);

  always_ff @(posedge clk) begin
    if (rst) begin
      v   <= '0;
      ctl <= '0;
    end else if (en) begin
      v         <= {v[3:0], in_valid};
      ctl.valid <= v[4];
      ctl.singular <= (dt == '0) || (LW'(dabs) < lim);
    end
  end

  for (genvar k = 0; k < m3i_pkg::NUM_ENT; k++) begin : g_cof
    always_ff @(posedge clk) begin
      if (en) begin
        pa[k]   <= m[m3i_pkg::COF_A[k]] * m[m3i_pkg::COF_B[k]];
        pb[k]   <= m[m3i_pkg::COF_C[k]] * m[m3i_pkg::COF_D[k]];
        cf2[k]  <= CW'(pa[k]) - CW'(pb[k]);
        cf3[k]  <= cf2[k];
        cf4[k]  <= cf3[k];
        cf5[k]  <= cf4[k];
        cneg[k] <= cf5[k][CW-1];
        cmag[k] <= cf5[k][CW-1] ? CW'(~cf5[k] + CW'(1)) : CW'(cf5[k]);
      end
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_row
    always_ff @(posedge clk) begin
      if (en) begin
        row1[j] <= m[j];
        row2[j] <= row1[j];
        pl[j]   <= row2[j] * $signed({1'b0, cf2[3*j][W-1:0]});
        ph[j]   <= row2[j] * $signed(cf2[3*j][2*W:W]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sl   <= SW'(pl[0]) + SW'(pl[1]) + SW'(pl[2]);
      sh   <= SW'(ph[0]) + SW'(ph[1]) + SW'(ph[2]);
      dt   <= (DW'(sh) <<< W) + DW'(sl);
      dneg <= dt[DW-1];
      dmag <= dabs;
    end
  end

endmodule

### rtl/m3i_div_lane.sv
`timescale 1ns / 1ps
module m3i_div_lane #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic           clk,
  input  logic           en,
  input  logic [2*W:0]   cmag,
  input  logic           cneg,
  input  logic [3*W+2:0] dmag,
  input  logic           dneg,
  output logic [W-1:0]   q,
  output logic           ovf,
  output logic           neg
);

  localparam int CMW = 2 * W + 1;
  localparam int DMW = 3 * W + 3;
  localparam int NW  = CMW + 2 * F;
  localparam int RW0 = (NW > DMW + W) ? NW : DMW + W;
  localparam int RW  = RW0 + 1;

  logic [RW-1:0]  rem [W+1];
  logic [DMW-1:0] dv  [W+1];
  logic [W-1:0]   qb  [W+1];
  logic           ov  [W+1];
  logic           ng  [W+1];
  logic [RW-1:0]  num;

  assign num = RW'({cmag, {(2 * F){1'b0}}});

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num;
      dv[0]  <= dmag;
      qb[0]  <= '0;
      ov[0]  <= num >= (RW'(dmag) << W);
      ng[0]  <= cneg ^ dneg;
    end
  end

  for (genvar s = 1; s <= W; s++) begin : g_stage
    localparam int SH = W - s;
    logic [RW:0] t;
    assign t = {1'b0, rem[s-1]} - ((RW + 1)'(dv[s-1]) << SH);
    always_ff @(posedge clk) begin
      if (en) begin
        dv[s] <= dv[s-1];
        ov[s] <= ov[s-1];
        ng[s] <= ng[s-1];
        if (!t[RW]) begin
          rem[s] <= t[RW-1:0];
          qb[s]  <= qb[s-1] | (W'(1) << SH);
        end else begin
          rem[s] <= rem[s-1];
          qb[s]  <= qb[s-1];
        end
      end
    end
  end

  assign q   = qb[W];
  assign ovf = ov[W];
  assign neg = ng[W];

endmodule

### rtl/m3i_merge.sv
`timescale 1ns / 1ps
module m3i_merge #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  m3i_pkg::m3i_ctl_t    ctl,
  input  logic [W-1:0]         q   [m3i_pkg::NUM_ENT],
  input  logic                 ovf [m3i_pkg::NUM_ENT],
  input  logic                 neg [m3i_pkg::NUM_ENT],
  output logic signed [W-1:0]  r   [m3i_pkg::NUM_ENT],
  output logic                 singular,
  output logic                 saturated,
  output logic                 valid
);

  localparam logic [W-1:0] MAXV = {1'b0, {(W - 1){1'b1}}};
  localparam logic [W-1:0] MINV = {1'b1, {(W - 1){1'b0}}};
  localparam logic [W-1:0] ONE  = W'(1) << F;

  logic [W-1:0]               val [m3i_pkg::NUM_ENT];
  logic [m3i_pkg::NUM_ENT-1:0] sat;

  for (genvar k = 0; k < m3i_pkg::NUM_ENT; k++) begin : g_ent
    always_comb begin
      sat[k] = ovf[k] || (neg[k] ? (q[k] > MINV) : (q[k] > MAXV));
      if (sat[k]) begin
        val[k] = neg[k] ? MINV : MAXV;
      end else begin
        val[k] = neg[k] ? (~q[k] + W'(1)) : q[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (ctl.singular) begin
          r[k] <= (k % 4 == 0) ? ONE : '0;
        end else begin
          r[k] <= val[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      singular  <= ctl.singular;
      saturated <= !ctl.singular && (|sat);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= ctl.valid;
    end
  end

endmodule

### rtl/matrix3_inverse.sv
`timescale 1ns / 1ps
// 3x3 matrix inverse by adjugate over determinant, signed fixed point.
// mat: one beat carries a whole matrix, m00..m22 row by row.
// inv: one beat carries the inverse r00..r22 plus singular and saturated.
// cfg_we/cfg_data write det_threshold; write it only with the pipe empty.
// Cofactors and determinant take six stages of 32x32- and 32x33-bit multiplies and
// adds; nine divider lanes, one per entry, then resolve one quotient bit
// per stage (WORD_BITS + 1 stages); a final stage clamps and merges.
// Throughput: one matrix per cycle, back to back, while inv is not held.
// The whole pipe advances together: with inv held (valid high, ready low)
// every stage freezes and mat.ready falls in the same cycle.
// Singular matrices give the identity with singular set.
// Reset: pipe emptied, det_threshold back to 1.
module matrix3_inverse #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [m3i_pkg::THR_BITS-1:0] cfg_data,
  m3i_in_if.sink                       mat,
  m3i_out_if.source                    inv
);

  localparam int W = WORD_BITS;

  logic [m3i_pkg::THR_BITS-1:0] thr;
  logic                         en;
  logic signed [W-1:0]          m [m3i_pkg::NUM_ENT];
  m3i_pkg::m3i_ctl_t            fctl;
  m3i_pkg::m3i_ctl_t            cd [W+1];
  logic [2*W:0]                 cmag [m3i_pkg::NUM_ENT];
  logic                         cneg [m3i_pkg::NUM_ENT];
  logic [3*W+2:0]               dmag;
  logic                         dneg;
  logic [W-1:0]                 q    [m3i_pkg::NUM_ENT];
  logic                         ovf  [m3i_pkg::NUM_ENT];
  logic                         neg  [m3i_pkg::NUM_ENT];
  logic signed [W-1:0]          r    [m3i_pkg::NUM_ENT];

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= m3i_pkg::THR_BITS'(m3i_pkg::THR_RESET);
    end else if (cfg_we) begin
      thr <= cfg_data;
    end
  end

  assign en        = !inv.valid || inv.ready;
  assign mat.ready = en;

  assign m[0] = mat.m00;
  assign m[1] = mat.m01;
  assign m[2] = mat.m02;
  assign m[3] = mat.m10;
  assign m[4] = mat.m11;
  assign m[5] = mat.m12;
  assign m[6] = mat.m20;
  assign m[7] = mat.m21;
  assign m[8] = mat.m22;

  m3i_front #(.W(W), .F(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (mat.valid),
    .m        (m),
    .thr      (thr),
    .ctl      (fctl),
    .cmag     (cmag),
    .cneg     (cneg),
    .dmag     (dmag),
    .dneg     (dneg)
  );

  // control rides alongside the divider lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= W; i++) begin
        cd[i] <= '0;
      end
    end else if (en) begin
      cd[0] <= fctl;
      for (int i = 1; i <= W; i++) begin
        cd[i] <= cd[i-1];
      end
    end
  end

  for (genvar k = 0; k < m3i_pkg::NUM_ENT; k++) begin : g_lane
    m3i_div_lane #(.W(W), .F(FRAC_BITS)) u_lane (
      .clk  (clk),
      .en   (en),
      .cmag (cmag[k]),
      .cneg (cneg[k]),
      .dmag (dmag),
      .dneg (dneg),
      .q    (q[k]),
      .ovf  (ovf[k]),
      .neg  (neg[k])
    );
  end

  m3i_merge #(.W(W), .F(FRAC_BITS)) u_merge (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .ctl       (cd[W]),
    .q         (q),
    .ovf       (ovf),
    .neg       (neg),
    .r         (r),
    .singular  (inv.singular),
    .saturated (inv.saturated),
    .valid     (inv.valid)
  );

  assign inv.r00 = r[0];
  assign inv.r01 = r[1];
  assign inv.r02 = r[2];
  assign inv.r10 = r[3];
  assign inv.r11 = r[4];
  assign inv.r12 = r[5];
  assign inv.r20 = r[6];
  assign inv.r21 = r[7];
  assign inv.r22 = r[8];

endmodule

### bench/tb_matrix3_inverse.sv
`timescale 1ns / 1ps
module tb_matrix3_inverse;

  localparam int W = 32;
  localparam int F = 16;
  localparam int LAT = W + 8;
  localparam longint LIMIT = 400000;

  typedef logic signed [W-1:0] word_t;
  typedef word_t mat_t [9];

  typedef struct {
    word_t r [9];
    logic  singular;
    logic  saturated;
  } inverse_t;

  // Exact inverse: adjugate / determinant, truncated, saturated.
  function automatic inverse_t invert(mat_t m, logic [m3i_pkg::THR_BITS-1:0] thr);
    inverse_t res;
    logic signed [127:0] c [9];
    logic signed [127:0] det, num, q, ad, lim;
    logic signed [127:0] pmax, nmin;
    pmax = (128'sd1 <<< (W - 1)) - 1;
    nmin = -(128'sd1 <<< (W - 1));
    for (int k = 0; k < 9; k++)
      c[k] = 128'(m[m3i_pkg::COF_A[k]]) * 128'(m[m3i_pkg::COF_B[k]])
           - 128'(m[m3i_pkg::COF_C[k]]) * 128'(m[m3i_pkg::COF_D[k]]);
    det = 128'(m[0]) * c[0] + 128'(m[1]) * c[3] + 128'(m[2]) * c[6];
    ad = det < 0 ? -det : det;
    lim = 128'(thr) <<< (2 * F);
    res.saturated = 1'b0;
    if (det == 0 || ad < lim) begin
      foreach (res.r[k]) res.r[k] = (k % 4 == 0) ? word_t'(1 << F) : '0;
      res.singular = 1'b1;
      return res;
    end
    res.singular = 1'b0;
    for (int k = 0; k < 9; k++) begin
      num = c[k] <<< (2 * F);
      q = num / det;
      if (q > pmax) begin q = pmax; res.saturated = 1'b1; end
      if (q < nmin) begin q = nmin; res.saturated = 1'b1; end
      res.r[k] = q[W-1:0];
    end
    return res;
  endfunction

  class inverse_scoreboard;
    inverse_t pending[$];
    int errors;
    int matched;
    int singular_seen;
    int saturated_seen;

    function void note_matrix(mat_t m, logic [m3i_pkg::THR_BITS-1:0] thr);
      pending.push_back(invert(m, thr));
    endfunction

    function void check_inverse(inverse_t got);
      inverse_t exp_r;
      if (pending.size() == 0) begin
        $error("inverse beat with nothing pending");
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      for (int k = 0; k < 9; k++)
        if (got.r[k] !== exp_r.r[k]) begin
          $error("r%0d%0d: expected %0d, got %0d", k / 3, k % 3, exp_r.r[k], got.r[k]);
          errors++;
        end
      if (got.singular !== exp_r.singular) begin
        $error("singular: expected %0b, got %0b", exp_r.singular, got.singular);
        errors++;
      end
      if (got.saturated !== exp_r.saturated) begin
        $error("saturated: expected %0b, got %0b", exp_r.saturated, got.saturated);
        errors++;
      end
      matched++;
      if (exp_r.singular) singular_seen++;
      if (exp_r.saturated) saturated_seen++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [m3i_pkg::THR_BITS-1:0] cfg_data = '0;
  logic [m3i_pkg::THR_BITS-1:0] threshold = m3i_pkg::THR_BITS'(m3i_pkg::THR_RESET);
  int send_idle = 0;
  int recv_stall = 0;
  longint cycles = 0;
  int sent = 0;

  m3i_in_if #(W) mat ();
  m3i_out_if #(W) inv ();

  matrix3_inverse #(.WORD_BITS(W), .FRAC_BITS(F)) dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .mat(mat), .inv(inv)
  );

  inverse_scoreboard sb = new();

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    mat.valid = 1'b0;
    {mat.m00, mat.m01, mat.m02, mat.m10, mat.m11, mat.m12, mat.m20, mat.m21, mat.m22} = '0;
    inv.ready = 1'b0;
  end

  always @(posedge clk) begin
    inverse_t got;
    cycles++;
    if (!rst && mat.valid && mat.ready) begin
      sb.note_matrix('{mat.m00, mat.m01, mat.m02, mat.m10, mat.m11, mat.m12,
                       mat.m20, mat.m21, mat.m22}, threshold);
      sent++;
    end
    if (!rst && inv.valid && inv.ready) begin
      got.r = '{inv.r00, inv.r01, inv.r02, inv.r10, inv.r11, inv.r12,
                inv.r20, inv.r21, inv.r22};
      got.singular = inv.singular;
      got.saturated = inv.saturated;
      sb.check_inverse(got);
    end
    if (cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(negedge clk) begin
    inv.ready <= ($urandom_range(99) >= recv_stall);
  end

  function automatic word_t rand_word(int mode);
    case (mode)
      0: return word_t'($urandom);
      1: return word_t'($signed($urandom_range(8 << F)) - (4 << F));
      2: return word_t'($signed($urandom_range(512)) - 256);
      default: return $urandom_range(1) ? word_t'(32'h7fffffff) : word_t'(32'h80000000);
    endcase
  endfunction

  task automatic send_matrix(mat_t m);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      mat.valid <= 1'b0;
      @(negedge clk);
    end
    mat.valid <= 1'b1;
    {mat.m00, mat.m01, mat.m02, mat.m10, mat.m11, mat.m12, mat.m20, mat.m21, mat.m22}
      <= {m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8]};
    @(posedge clk);
    while (!mat.ready) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    mat.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
  endtask

  task automatic write_threshold(logic [m3i_pkg::THR_BITS-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    threshold = v;
  endtask

  task automatic random_matrix(output mat_t m);
    int mode;
    mode = $urandom_range(9);
    mode = mode < 2 ? 0 : mode < 7 ? 1 : mode < 9 ? 2 : 3;
    foreach (m[k]) m[k] = rand_word(mode);
    case ($urandom_range(9))
      0: foreach (m[k]) if (k >= 6) m[k] = m[k - 3];
      1: foreach (m[k]) m[k] = (k % 4 == 0) ? rand_word(1) : '0;
      default: ;
    endcase
  endtask

  initial begin
    mat_t m;
    logic [m3i_pkg::THR_BITS-1:0] thr_set [4];
    int idle_set [4];
    int stall_set [4];
    thr_set = '{31'd0, 31'd1, 31'h7fffffff, 31'd16};
    idle_set = '{0, 68, 0, 38};
    stall_set = '{0, 0, 68, 38};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: identity, extremes, singular, saturation
    m = '{default: '0}; m[0] = 1 << F; m[4] = 1 << F; m[8] = 1 << F; send_matrix(m);
    m = '{default: '0}; send_matrix(m);
    m = '{default: word_t'(32'h7fffffff)}; send_matrix(m);
    m = '{default: word_t'(32'h80000000)}; send_matrix(m);
    m = '{default: '0}; m[0] = 32'h7fffffff; m[4] = 32'h80000000; m[8] = 32'hffffffff;
    send_matrix(m);
    m = '{default: '0}; m[0] = 1; m[4] = 1; m[8] = 1; send_matrix(m);
    m = '{default: '0}; m[0] = 2 << F; m[4] = -(3 << F); m[8] = 1 << (F - 4);
    send_matrix(m);
    m = '{default: '0}; m[0] = 256; m[4] = 256; m[8] = 256; send_matrix(m);
    m = '{default: '0}; m[2] = 1 << F; m[4] = -(1 << F); m[6] = 5 << F; send_matrix(m);
    m = '{32'h12345678, 32'hedcba987, 32'h00010000, 32'h55555555, 32'haaaaaaaa,
          32'h0f0f0f0f, 32'hf0f0f0f0, 32'h33333333, 32'hcccccccc};
    send_matrix(m);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_threshold(thr_set[ph]);
      send_idle = idle_set[ph];
      recv_stall = stall_set[ph];
      for (int i = 0; i < 125; i++) begin
        random_matrix(m);
        send_matrix(m);
        if (ph == 1 && i == 60) drain();
      end
      drain();
    end

    $display("%0d matrices sent, %0d inverses checked (%0d singular, %0d saturated)",
             sent, sb.matched, sb.singular_seen, sb.saturated_seen);
    $display("thresholds 0, 1, max and 16 under four idle and stall mixes");
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
